### rtl/core/websocket_frame_receiver_defines.svh
// assertion macros used by the checker of the frame receiver
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

// condition must hold in the same cycle as its trigger
`define WSFR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed in the same cycle");

// condition must hold in the cycle after its trigger
`define WSFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed one cycle later");

`endif

### rtl/core/wsfr_pkg.sv
package wsfr_pkg;

   // result event codes
   localparam logic [2:0] EV_HEADER   = 3'd0;
   localparam logic [2:0] EV_PAYLOAD  = 3'd1;
   localparam logic [2:0] EV_CLOSE    = 3'd2;
   localparam logic [2:0] EV_UNKNOWN  = 3'd3;
   localparam logic [2:0] EV_UNMASKED = 3'd4;
   localparam logic [2:0] EV_IGNORED  = 3'd5;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       frame_end;
      logic       fin_clear;
   } result_type;

endpackage

### rtl/core/websocket_frame_receiver.sv
// a byte's result item is registered in the output register, or in the skid entry while the output stalls
// throughput: one byte per cycle, sustained, as long as rsp_stall stays low
// a two-entry output buffer (output register plus skid) absorbs result back-pressure
// reset (synchronous, active high) returns the parser to expecting an opcode byte,
// clears length, count and masking key state and empties the output buffer
module websocket_frame_receiver
   import wsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_frame_end,
   output logic       rsp_fin_clear
);

   // an item is taken whenever the skid stage is empty
   logic       accept;
   result_type parse_result;
   result_type out_result;

   assign accept = req_valid && !req_stall;

   // frame header and payload parser: state moves only on an accepted item
   wsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_data_byte),
      .result    (parse_result)
   );

   // result register with skid entry, stall is registered so it never
   // depends combinationally on rsp_stall
   wsfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_result  (parse_result),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   // unpack the result item onto its ports
   assign rsp_event_res    = out_result.event_res;
   assign rsp_payload_byte = out_result.payload_byte;
   assign rsp_frame_opcode = out_result.frame_opcode;
   assign rsp_frame_end    = out_result.frame_end;
   assign rsp_fin_clear    = out_result.fin_clear;

endmodule

### rtl/core/wsfr_parser.sv
module wsfr_parser
   import wsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] in_byte,
   output result_type result
);

   localparam logic [2:0] PH_OPCODE  = 3'd0;
   localparam logic [2:0] PH_LEN8    = 3'd1;
   localparam logic [2:0] PH_LEN16   = 3'd2;
   localparam logic [2:0] PH_LEN64   = 3'd3;
   localparam logic [2:0] PH_MASK    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_ENDED   = 3'd6;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [63:0] total_ff, total_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  key_ff [4];
   logic        key_we;
   logic [63:0] seen_ff, seen_in;
   logic [3:0]  hdr_next;
   logic [63:0] seen_next;

   assign hdr_next  = hdr_cnt_ff + 4'd1;
   assign seen_next = seen_ff + 64'd1;

   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      total_in   = total_ff;
      hdr_cnt_in = hdr_cnt_ff;
      seen_in    = seen_ff;
      key_we     = 1'b0;
      result.event_res    = EV_HEADER;
      result.payload_byte = 8'd0;
      result.frame_end    = 1'b0;
      result.fin_clear    = 1'b0;
      unique case (phase_ff)
         PH_OPCODE: begin
            result.fin_clear = ~in_byte[7];
            opcode_in = in_byte[3:0];
            if (opcode_in == OP_TEXT || opcode_in == OP_BINARY ||
                opcode_in == OP_PING || opcode_in == OP_PONG) begin
               phase_in = PH_LEN8;
            end else if (opcode_in == OP_CLOSE) begin
               result.event_res = EV_CLOSE;
               phase_in = PH_ENDED;
            end else begin
               result.event_res = EV_UNKNOWN;
               phase_in = PH_ENDED;
            end
         end
         PH_LEN8: begin
            if (!in_byte[7]) begin
               result.event_res = EV_UNMASKED;
               phase_in = PH_ENDED;
            end else begin
               hdr_cnt_in = 4'd0;
               if (in_byte[6:0] == 7'd126) begin
                  total_in = 64'd0;
                  phase_in = PH_LEN16;
               end else if (in_byte[6:0] == 7'd127) begin
                  total_in = 64'd0;
                  phase_in = PH_LEN64;
               end else begin
                  total_in = {57'd0, in_byte[6:0]};
                  phase_in = PH_MASK;
               end
            end
         end
         PH_LEN16, PH_LEN64: begin
            total_in   = {total_ff[55:0], in_byte};
            hdr_cnt_in = hdr_next;
            if (hdr_next >= ((phase_ff == PH_LEN16) ? 4'd2 : 4'd8)) begin
               hdr_cnt_in = 4'd0;
               phase_in   = PH_MASK;
            end
         end
         PH_MASK: begin
            key_we     = 1'b1;
            hdr_cnt_in = hdr_next;
            if (hdr_next >= 4'd4) begin
               hdr_cnt_in = 4'd0;
               seen_in    = 64'd0;
               if (total_ff == 64'd0) begin
                  result.frame_end = 1'b1;
                  phase_in = PH_OPCODE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result.event_res    = EV_PAYLOAD;
            result.payload_byte = in_byte ^ key_ff[seen_ff[1:0]];
            seen_in = seen_next;
            if (seen_next >= total_ff) begin
               result.frame_end = 1'b1;
               phase_in = PH_OPCODE;
            end
         end
         default: begin
            result.event_res = EV_IGNORED;
            phase_in = PH_ENDED;
         end
      endcase
      result.frame_opcode = opcode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPCODE;
         opcode_ff  <= 4'd0;
         total_ff   <= 64'd0;
         hdr_cnt_ff <= 4'd0;
         seen_ff    <= 64'd0;
         key_ff[0]  <= 8'd0;
         key_ff[1]  <= 8'd0;
         key_ff[2]  <= 8'd0;
         key_ff[3]  <= 8'd0;
      end else if (in_accept) begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         total_ff   <= total_in;
         hdr_cnt_ff <= hdr_cnt_in;
         seen_ff    <= seen_in;
         if (key_we) begin
            key_ff[hdr_cnt_ff[1:0]] <= in_byte;
         end
      end
   end

endmodule

### rtl/core/wsfr_out_buf.sv
module wsfr_out_buf
   import wsfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  result_type in_result,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_result
);

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       accept;
   logic       out_free;

   assign in_stall   = skid_valid_ff;
   assign accept     = in_valid && !skid_valid_ff;
   assign out_free   = !out_valid_ff || !out_stall;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (out_free && skid_valid_ff) begin
         // drain the skid entry first to keep order
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (out_free) begin
         out_in       = in_result;
         out_valid_in = accept;
      end else if (accept) begin
         skid_in       = in_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

### rtl/core/wsfr_checker.sv
`include "websocket_frame_receiver_defines.svh"

module wsfr_checker
   import wsfr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_payload_byte,
   input logic [3:0] rsp_frame_opcode,
   input logic       rsp_frame_end,
   input logic       rsp_fin_clear
);

   logic        rsp_held;
   logic        end_kind_ok;
   logic        fin_kind_ok;
   logic [16:0] rsp_fields;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign end_kind_ok = rsp_event_res == EV_HEADER || rsp_event_res == EV_PAYLOAD;
   assign fin_kind_ok = !rsp_frame_end && rsp_event_res != EV_PAYLOAD &&
                        rsp_event_res != EV_UNMASKED && rsp_event_res != EV_IGNORED;
   assign rsp_fields  = {rsp_event_res, rsp_payload_byte, rsp_frame_opcode,
                         rsp_frame_end, rsp_fin_clear};

   // payload data only travels with payload items
   `WSFR_ASSERT_SAME(a_payload_zero, rsp_valid && rsp_event_res != EV_PAYLOAD, rsp_payload_byte == 8'd0)

   // a frame completes only on a header or payload item
   `WSFR_ASSERT_SAME(a_end_kind, rsp_valid && rsp_frame_end, end_kind_ok)

   // clear fin is reported only on opcode bytes, which never end a frame
   `WSFR_ASSERT_SAME(a_fin_kind, rsp_valid && rsp_fin_clear, fin_kind_ok)

   // a stalled result item stays put
   `WSFR_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_fields))

   // input only stalls while the output register holds an item
   `WSFR_ASSERT_SAME(a_stall_full, req_stall, rsp_valid)

endmodule

bind websocket_frame_receiver wsfr_checker u_checker (.*);
